// ===== src/apsk_pkg.sv =====
// ----------------------------------------------------------------------------
// APSK mapper / demapper package
// Shared constants, register and operation codes, the pipeline item type, the
// CORDIC arctangent table and the round-and-saturate function.
// ----------------------------------------------------------------------------
package apsk_pkg;

  localparam int SW           = 16;               // sample and point width
  localparam int MAP_DEPTH    = 256;
  localparam int MAP_AW       = $clog2(MAP_DEPTH);
  localparam int MAX_RINGS    = 8;
  localparam int RING_W       = 3;
  localparam int CNT_W        = 8;
  localparam int SUM_W        = 12;               // sum of up to eight counts
  localparam int NR_W         = 4;
  localparam int CORDIC_STEPS = 20;
  localparam int MAG_W        = 2 * SW;
  localparam int CMP_W        = (MAG_W > 32) ? MAG_W : 32;
  localparam int VX_W         = SW + 8 + 3;       // vectoring datapath
  localparam int RX_W         = 36;               // rotation datapath
  localparam int ZR_W         = 34;               // rotation residual angle
  localparam int DIV_STAGES   = 4;
  localparam int DIV_BPS      = 32 / DIV_STAGES;  // quotient bits per stage
  localparam int CFG_IW       = 3;
  localparam int CFG_DW       = 64;

  localparam logic [29:0] CORDIC_KQ30 = 30'd652032874;

  // Operations
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_MOD   = 2'd1;
  localparam logic [1:0] OP_DEMOD = 2'd2;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_NUM_RINGS   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_RING_POINTS = 3'd1;
  localparam logic [CFG_IW-1:0] REG_RADIUS_LO   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_RADIUS_HI   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PHASE_LO    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_PHASE_HI    = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SLICER_LO   = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SLICER_HI   = 3'd7;

  // Reset values
  localparam logic [NR_W-1:0]  NUM_RINGS_RST   = 4'd1;
  localparam logic [63:0]      RING_POINTS_RST = 64'd4;
  localparam logic [63:0]      RADIUS_LO_RST   = 64'd8192;

  // Arctangent of 2^-i in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304
  };

  // One item as it travels down the pipeline
  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        map_index;
    logic [7:0]        map_value;
    logic [7:0]        symbol;
    logic [MAG_W-1:0]  mag2;
    logic [31:0]       ang;
    logic [RING_W-1:0] ring;
    logic [CNT_W-1:0]  cnt;
    logic [SUM_W-1:0]  base;
    logic [31:0]       dv;
    logic [39:0]       prod;
    logic [SUM_W-1:0]  shat;
    logic              shok;
    logic [7:0]        sym_out;
    logic [7:0]        pidx;
    logic [7:0]        s0;
    logic [15:0]       radius;
    logic [15:0]       phase;
    logic              err;
  } item_t;

  // Round to nearest (half up) from 2^-29 units to Q2.13 and saturate
  function automatic logic signed [SW-1:0] round_sat(input logic signed [RX_W-1:0] v);
    logic signed [RX_W-1:0] t;
    t = (v + RX_W'(32768)) >>> 16;
    if (t > RX_W'((1 <<< (SW - 1)) - 1)) begin
      return {1'b0, {(SW-1){1'b1}}};
    end else if (t < RX_W'(-(1 <<< (SW - 1)))) begin
      return {1'b1, {(SW-1){1'b0}}};
    end
    return t[SW-1:0];
  endfunction

endpackage

// ===== src/apsk_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data; a read in the
// cycle of a write to the same address returns the old contents.
// ----------------------------------------------------------------------------
module apsk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/apsk_vec.sv =====
// ----------------------------------------------------------------------------
// APSK vectoring CORDIC
// Pipelined sample angle, one CORDIC step per stage, result in turns.
// ----------------------------------------------------------------------------
module apsk_vec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  apsk_pkg::item_t             in_item,
  input  logic signed [apsk_pkg::SW-1:0] in_i,
  input  logic signed [apsk_pkg::SW-1:0] in_q,
  output logic                        out_valid,
  output apsk_pkg::item_t             out_item
);
  import apsk_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic                   v_r  [N+1];
  logic signed [VX_W-1:0] x_r  [N+1];
  logic signed [VX_W-1:0] y_r  [N+1];
  logic [31:0]            z_r  [N+1];
  logic                   zf_r [N+1];
  item_t                  sd_r [N+1];

  logic signed [VX_W-1:0] xe, ye, x0, y0;
  logic                   neg;

  // Scale by 256 and fold the left half plane
  always_comb begin
    xe  = {{(VX_W-SW-8){in_i[SW-1]}}, in_i, 8'd0};
    ye  = {{(VX_W-SW-8){in_q[SW-1]}}, in_q, 8'd0};
    neg = in_i[SW-1];
    x0  = neg ? -xe : xe;
    y0  = neg ? -ye : ye;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 0; k < N; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  // Rotate toward the x axis, one step per stage
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x0;
      y_r[0]  <= y0;
      z_r[0]  <= neg ? 32'h8000_0000 : 32'd0;
      zf_r[0] <= (in_i == '0) && (in_q == '0);
      sd_r[0] <= in_item;
      for (int k = 0; k < N; k++) begin
        if (!y_r[k][VX_W-1]) begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ATAN_TURNS[k];
        end else begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ATAN_TURNS[k];
        end
        zf_r[k+1] <= zf_r[k];
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  // Zero sample has angle zero
  always_comb begin
    out_valid    = v_r[N];
    out_item     = sd_r[N];
    out_item.ang = zf_r[N] ? 32'd0 : z_r[N];
  end

endmodule

// ===== src/apsk_div.sv =====
// ----------------------------------------------------------------------------
// APSK offset divider
// Pipelined restoring division round((s0 * 2^32) / n) with s0 < n.
// ----------------------------------------------------------------------------
module apsk_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  apsk_pkg::item_t in_item,
  output logic            out_valid,
  output apsk_pkg::item_t out_item,
  output logic [31:0]     out_q
);
  import apsk_pkg::*;

  localparam int N = DIV_STAGES;

  logic             v_r   [N+1];
  logic [CNT_W-1:0] rem_r [N+1];
  logic [31:0]      q_r   [N+1];
  item_t            sd_r  [N+1];

  logic [CNT_W-1:0] rem_n [N];
  logic [31:0]      q_n   [N];

  // Work DIV_BPS quotient bits per stage; low numerator bits hold n/2
  always_comb begin
    logic [CNT_W:0] t;
    logic [31:0]    hw;
    logic [CNT_W-1:0] r;
    logic [31:0]    q;
    for (int j = 0; j < N; j++) begin
      hw = {{(32-CNT_W+1){1'b0}}, sd_r[j].cnt[CNT_W-1:1]};
      r  = rem_r[j];
      q  = q_r[j];
      for (int b = 0; b < DIV_BPS; b++) begin
        t = {r, hw[31 - DIV_BPS*j - b]};
        if (t >= {1'b0, sd_r[j].cnt}) begin
          t = t - {1'b0, sd_r[j].cnt};
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
        r = t[CNT_W-1:0];
      end
      rem_n[j] = r;
      q_n[j]   = q;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 0; k < N; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  // Advance partial remainders and quotients
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= in_item.s0;
      q_r[0]   <= 32'd0;
      sd_r[0]  <= in_item;
      for (int k = 0; k < N; k++) begin
        rem_r[k+1] <= rem_n[k];
        q_r[k+1]   <= q_n[k];
        sd_r[k+1]  <= sd_r[k];
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_item  = sd_r[N];
  assign out_q     = q_r[N];

endmodule

// ===== src/apsk_rot.sv =====
// ----------------------------------------------------------------------------
// APSK rotation CORDIC
// Pipelined polar to rectangular conversion, one CORDIC step per stage.
// ----------------------------------------------------------------------------
module apsk_rot (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  apsk_pkg::item_t               in_item,
  input  logic [31:0]                   in_x0,
  input  logic [31:0]                   in_ang,
  output logic                          out_valid,
  output apsk_pkg::item_t               out_item,
  output logic                          out_neg,
  output logic signed [apsk_pkg::RX_W-1:0] out_x,
  output logic signed [apsk_pkg::RX_W-1:0] out_y
);
  import apsk_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic                   v_r   [N+1];
  logic signed [RX_W-1:0] x_r   [N+1];
  logic signed [RX_W-1:0] y_r   [N+1];
  logic [ZR_W-1:0]        z_r   [N+1];
  logic                   neg_r [N+1];
  item_t                  sd_r  [N+1];

  logic [31:0] ad, a2;
  logic        neg;

  // Fold angles of the left half plane by a half turn
  always_comb begin
    ad  = in_ang - 32'h4000_0000;
    neg = ad < 32'h8000_0000;
    a2  = neg ? (in_ang - 32'h8000_0000) : in_ang;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 0; k < N; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  // Rotate the residual angle to zero, one step per stage
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= {{(RX_W-32){1'b0}}, in_x0};
      y_r[0]   <= '0;
      z_r[0]   <= {{(ZR_W-32){a2[31]}}, a2};
      neg_r[0] <= neg;
      sd_r[0]  <= in_item;
      for (int k = 0; k < N; k++) begin
        if (!z_r[k][ZR_W-1]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ZR_W'(ATAN_TURNS[k]);
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ZR_W'(ATAN_TURNS[k]);
        end
        neg_r[k+1] <= neg_r[k];
        sd_r[k+1]  <= sd_r[k];
      end
    end
  end

  assign out_valid = v_r[N];
  assign out_item  = sd_r[N];
  assign out_neg   = neg_r[N];
  assign out_x     = x_r[N];
  assign out_y     = y_r[N];

endmodule

// ===== src/apsk_symbol_mapper_demapper.sv =====
// ----------------------------------------------------------------------------
// APSK symbol mapper and hard demapper
// Ring-based APSK modulation of symbols and hard decision of received samples
// with re-modulation of the decided symbol.
// ----------------------------------------------------------------------------
// The block takes one item every clock while no result is held and gives one
// result per item, in order; the path runs through the two 20-step CORDIC
// pipelines, the 4-stage offset divider and the map reads. A stalled result
// stalls the whole pipeline and in_ready falls in the same cycle. Load items
// write the symbol map and its inverse in place; a symbol or decided index
// whose map entry was never loaded gives an undefined point. Configuration
// writes are registered; the user must make them only while the pipeline is
// empty, and the block itself does not enforce this.
module apsk_symbol_mapper_demapper (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [7:0]                     in_map_index,
  input  logic [7:0]                     in_map_value,
  input  logic [7:0]                     in_symbol,
  input  logic signed [apsk_pkg::SW-1:0] in_sample_i,
  input  logic signed [apsk_pkg::SW-1:0] in_sample_q,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_symbol_out,
  output logic [2:0]                     out_ring_index,
  output logic signed [apsk_pkg::SW-1:0] out_point_i,
  output logic signed [apsk_pkg::SW-1:0] out_point_q,
  output logic                           out_range_error,
  input  logic                           cfg_we,
  input  logic [apsk_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [apsk_pkg::CFG_DW-1:0]    cfg_wdata
);
  import apsk_pkg::*;

  // Configuration registers
  logic [NR_W-1:0] num_rings_r;
  logic [63:0]     ring_points_r, radius_lo_r, radius_hi_r;
  logic [63:0]     phase_lo_r, phase_hi_r, slicer_lo_r;
  logic [47:0]     slicer_hi_r;

  // Derived configuration
  logic [NR_W-1:0]  nr_r, nr_nxt;
  logic [SUM_W-1:0] pre_r [MAX_RINGS+1];
  logic [SUM_W-1:0] pre_nxt [MAX_RINGS+1];
  logic [SUM_W-1:0] total_r, total_nxt;
  logic [31:0]      thsq_r [MAX_RINGS-1];
  logic [CNT_W-1:0] cnt_a [MAX_RINGS];
  logic [15:0]      rad_a [MAX_RINGS];
  logic [15:0]      ph_a  [MAX_RINGS];
  logic [15:0]      th_a  [MAX_RINGS-1];

  logic en;

  // Stage registers
  logic signed [SW-1:0]    s1_i_r, s1_q_r;
  logic signed [MAG_W-1:0] s1_sqi_r, s1_sqq_r;
  logic  s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r;
  logic  s10_v_r;
  item_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r, s9_r, s10_r;
  item_t s1_nxt;
  item_t s1_side, s2_nxt, s3_nxt, s4_nxt, s5_nxt, s6_nxt, s7_nxt, s8_nxt, s9_nxt;
  logic [31:0] s10_ang_r, s10_x0_r;

  logic        vec_v, div_v, rot_v, rot_neg;
  item_t       vec_item, div_item, rot_item;
  logic [31:0] div_q;
  logic signed [RX_W-1:0] rot_x, rot_y, fx, fy;

  logic             sm_we, inv_we;
  logic [MAP_AW-1:0] sm_raddr;
  logic [7:0]       sm_rd, inv_rd, sym_mod;
  logic [45:0]      x0_prod;

  // Output register
  logic                 out_v_r;
  logic [7:0]           out_sym_r;
  logic [RING_W-1:0]    out_ring_r;
  logic signed [SW-1:0] out_pi_r, out_pq_r;
  logic                 out_err_r;
  logic                 fin_act, fin_ok;

  // Whole pipeline moves unless the result is held
  assign en       = !out_v_r || out_ready;
  assign in_ready = en;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rings_r   <= NUM_RINGS_RST;
      ring_points_r <= RING_POINTS_RST;
      radius_lo_r   <= RADIUS_LO_RST;
      radius_hi_r   <= '0;
      phase_lo_r    <= '0;
      phase_hi_r    <= '0;
      slicer_lo_r   <= '0;
      slicer_hi_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_RINGS:   num_rings_r   <= cfg_wdata[NR_W-1:0];
        REG_RING_POINTS: ring_points_r <= cfg_wdata;
        REG_RADIUS_LO:   radius_lo_r   <= cfg_wdata;
        REG_RADIUS_HI:   radius_hi_r   <= cfg_wdata;
        REG_PHASE_LO:    phase_lo_r    <= cfg_wdata;
        REG_PHASE_HI:    phase_hi_r    <= cfg_wdata;
        REG_SLICER_LO:   slicer_lo_r   <= cfg_wdata;
        REG_SLICER_HI:   slicer_hi_r   <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  // Split configuration words into per-ring lanes
  always_comb begin
    for (int k = 0; k < MAX_RINGS; k++) begin
      cnt_a[k] = ring_points_r[8*k +: 8];
      rad_a[k] = (k >= 4) ? radius_hi_r[16*(k%4) +: 16] : radius_lo_r[16*(k%4) +: 16];
      ph_a[k]  = (k >= 4) ? phase_hi_r[16*(k%4) +: 16] : phase_lo_r[16*(k%4) +: 16];
    end
    for (int k = 0; k < MAX_RINGS - 1; k++) begin
      th_a[k] = (k >= 4) ? slicer_hi_r[16*(k%4) +: 16] : slicer_lo_r[16*(k%4) +: 16];
    end
  end

  // Clamp ring count and build prefix sums of point counts
  always_comb begin
    if (num_rings_r == '0) begin
      nr_nxt = NR_W'(1);
    end else if (num_rings_r > NR_W'(MAX_RINGS)) begin
      nr_nxt = NR_W'(MAX_RINGS);
    end else begin
      nr_nxt = num_rings_r;
    end
    pre_nxt[0] = '0;
    for (int k = 0; k < MAX_RINGS; k++) begin
      pre_nxt[k+1] = pre_nxt[k] + SUM_W'(cnt_a[k]);
    end
    total_nxt = pre_nxt[nr_nxt];
  end

  // Register derived configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nr_r    <= NUM_RINGS_RST;
      total_r <= SUM_W'(RING_POINTS_RST[7:0]);
      pre_r[0] <= '0;
      for (int k = 1; k <= MAX_RINGS; k++) begin
        pre_r[k] <= SUM_W'(RING_POINTS_RST[7:0]);
      end
      for (int k = 0; k < MAX_RINGS - 1; k++) begin
        thsq_r[k] <= '0;
      end
    end else begin
      nr_r    <= nr_nxt;
      total_r <= total_nxt;
      for (int k = 0; k <= MAX_RINGS; k++) begin
        pre_r[k] <= pre_nxt[k];
      end
      for (int k = 0; k < MAX_RINGS - 1; k++) begin
        thsq_r[k] <= th_a[k] * th_a[k];
      end
    end
  end

  // Valid bits of the glue stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= vec_v;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= div_v;
    end
  end

  // Stage 1: capture the transfer and square the sample
  always_comb begin
    s1_nxt           = '0;
    s1_nxt.op        = in_op;
    s1_nxt.map_index = in_map_index;
    s1_nxt.map_value = in_map_value;
    s1_nxt.symbol    = in_symbol;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= s1_nxt;
      s1_i_r   <= in_sample_i;
      s1_q_r   <= in_sample_q;
      s1_sqi_r <= in_sample_i * in_sample_i;
      s1_sqq_r <= in_sample_q * in_sample_q;
    end
  end

  always_comb begin
    s1_side      = s1_r;
    s1_side.mag2 = $unsigned(s1_sqi_r) + $unsigned(s1_sqq_r);
  end

  apsk_vec u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_v_r),
    .in_item   (s1_side),
    .in_i      (s1_i_r),
    .in_q      (s1_q_r),
    .out_valid (vec_v),
    .out_item  (vec_item)
  );

  // Stage 2: slice the magnitude against the ring thresholds
  always_comb begin
    s2_nxt      = vec_item;
    s2_nxt.ring = RING_W'(nr_r - NR_W'(1));
    for (int k = MAX_RINGS - 2; k >= 0; k--) begin
      if ((k + 1 < nr_r) && (CMP_W'(vec_item.mag2) < CMP_W'(thsq_r[k]))) begin
        s2_nxt.ring = RING_W'(k);
      end
    end
  end

  // Stage 3: angle within the ring, point count and index base
  always_comb begin
    s3_nxt      = s2_r;
    s3_nxt.cnt  = cnt_a[s2_r.ring];
    s3_nxt.dv   = s2_r.ang - {ph_a[s2_r.ring], 16'd0};
    s3_nxt.base = pre_r[{1'b0, s2_r.ring}];
  end

  // Stage 4: scale the angle by the point count
  always_comb begin
    s4_nxt      = s3_r;
    s4_nxt.prod = s3_r.dv * s3_r.cnt;
  end

  // Stage 5: round to the nearest point, wrap and add the base
  always_comb begin
    logic [39:0]      pr;
    logic [CNT_W-1:0] kk;
    pr = s4_r.prod + 40'h80_0000_0000 / 40'd256;
    kk = pr[39:32];
    if (kk >= s4_r.cnt) begin
      kk = '0;
    end
    s5_nxt      = s4_r;
    s5_nxt.shat = s4_r.base + SUM_W'(kk);
  end

  always_comb begin
    s6_nxt      = s5_r;
    s6_nxt.shok = s5_r.shat < SUM_W'(MAP_DEPTH);
  end

  // Map writes of load items; inverse map read of demodulate items
  assign inv_we = en && s5_v_r && (s5_r.op == OP_LOAD) &&
                  (int'(s5_r.map_index) < MAP_DEPTH) && (int'(s5_r.map_value) < MAP_DEPTH);
  assign sm_we  = inv_we;

  apsk_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_inv_map (
    .clk   (clk),
    .we    (inv_we),
    .waddr (s5_r.map_value[MAP_AW-1:0]),
    .wdata (s5_r.map_index),
    .re    (en),
    .raddr (s5_r.shat[MAP_AW-1:0]),
    .rdata (inv_rd)
  );

  // Stage 7: pick the symbol to modulate and check its range
  always_comb begin
    if (s6_r.op == OP_DEMOD) begin
      sym_mod = s6_r.shok ? inv_rd : 8'd0;
    end else begin
      sym_mod = s6_r.symbol;
    end
    sm_raddr       = sym_mod[MAP_AW-1:0];
    s7_nxt         = s6_r;
    s7_nxt.sym_out = sym_mod;
    s7_nxt.err     = (int'(sym_mod) >= MAP_DEPTH) || (SUM_W'(sym_mod) >= total_r);
  end

  apsk_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_sym_map (
    .clk   (clk),
    .we    (sm_we),
    .waddr (s5_r.map_index[MAP_AW-1:0]),
    .wdata (s5_r.map_value),
    .re    (en),
    .raddr (sm_raddr),
    .rdata (sm_rd)
  );

  // Stage 8: find the ring of the map entry
  always_comb begin
    logic found;
    found       = 1'b0;
    s8_nxt      = s7_r;
    s8_nxt.pidx = sm_rd;
    s8_nxt.ring = '0;
    for (int k = MAX_RINGS - 1; k >= 0; k--) begin
      if ((k < nr_r) && (SUM_W'(sm_rd) < pre_r[k+1])) begin
        s8_nxt.ring = RING_W'(k);
        found       = 1'b1;
      end
    end
    s8_nxt.err = s7_r.err || !found;
  end

  // Stage 9: offset within the ring, radius and start phase
  always_comb begin
    logic [SUM_W-1:0] off;
    off           = SUM_W'(s8_r.pidx) - pre_r[{1'b0, s8_r.ring}];
    s9_nxt        = s8_r;
    s9_nxt.cnt    = cnt_a[s8_r.ring];
    s9_nxt.s0     = off[7:0];
    s9_nxt.radius = rad_a[s8_r.ring];
    s9_nxt.phase  = ph_a[s8_r.ring];
  end

  // Advance the glue stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
      s8_r <= s8_nxt;
      s9_r <= s9_nxt;
    end
  end

  apsk_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s9_v_r),
    .in_item   (s9_r),
    .out_valid (div_v),
    .out_item  (div_item),
    .out_q     (div_q)
  );

  // Stage 10: point angle and gain-compensated start radius
  assign x0_prod = div_item.radius * CORDIC_KQ30;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_r     <= div_item;
      s10_ang_r <= {div_item.phase, 16'd0} + div_q;
      s10_x0_r  <= x0_prod[45:14];
    end
  end

  apsk_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s10_v_r),
    .in_item   (s10_r),
    .in_x0     (s10_x0_r),
    .in_ang    (s10_ang_r),
    .out_valid (rot_v),
    .out_item  (rot_item),
    .out_neg   (rot_neg),
    .out_x     (rot_x),
    .out_y     (rot_y)
  );

  // Final stage: undo the half-turn fold, round, saturate and mask
  always_comb begin
    fx      = rot_neg ? -rot_x : rot_x;
    fy      = rot_neg ? -rot_y : rot_y;
    fin_act = (rot_item.op == OP_MOD) || (rot_item.op == OP_DEMOD);
    fin_ok  = fin_act && !rot_item.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= rot_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sym_r  <= rot_item.sym_out;
      out_ring_r <= fin_ok ? rot_item.ring : '0;
      out_pi_r   <= fin_ok ? round_sat(fx) : '0;
      out_pq_r   <= fin_ok ? round_sat(fy) : '0;
      out_err_r  <= fin_act && rot_item.err;
    end
  end

  assign out_valid       = out_v_r;
  assign out_symbol_out  = out_sym_r;
  assign out_ring_index  = out_ring_r;
  assign out_point_i     = out_pi_r;
  assign out_point_q     = out_pq_r;
  assign out_range_error = out_err_r;

`ifndef ASSERT_OFF
  // An error result carries no ring and no point
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |->
      (out_point_i == '0) && (out_point_q == '0) && (out_ring_index == '0))
    else $error("range error result with nonzero point");

  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  // Map writes come from load items only
  a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
    sm_we |-> s5_v_r && (s5_r.op == OP_LOAD))
    else $error("map written by a non-load item");

  // Clamped ring count stays in range
  a_nr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nr_r >= NR_W'(1)) && (nr_r <= NR_W'(MAX_RINGS)))
    else $error("ring count out of range");
`endif

endmodule

// ===== verif/apsk_symbol_mapper_demapper_test.sv =====
// ----------------------------------------------------------------------------
// APSK mapper / demapper testbench
// Loads a random permutation into the symbol map, then drives directed and
// random load, modulate and demodulate transfers under several ring setups
// and handshake idling patterns. A bit-true predictor computes each point
// and decision, and results are checked in order, field by field.
// ----------------------------------------------------------------------------
module apsk_symbol_mapper_demapper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import apsk_pkg::*;

  localparam logic [1:0] OP_IDLE = 2'd3;   // unused opcode, must echo only

  typedef struct {
    logic [7:0]         sym;
    logic [2:0]         ring;
    logic signed [15:0] pi;
    logic signed [15:0] pq;
    logic               err;
  } apsk_point_t;

  // Predictor state and in-order store of expected points
  class apsk_symbol_book;
    logic [63:0] regs [8];
    logic [7:0]  sym_map [256];
    logic [7:0]  inv_map [256];
    apsk_point_t pending_points [$];
    int          errors;
    int          checked;

    function new();
      regs = '{64'd1, 64'd4, 64'd8192, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
      foreach (sym_map[i]) begin
        sym_map[i] = '0;
        inv_map[i] = '0;
      end
    endfunction

    function void set_reg(int idx, logic [63:0] v);
      if (idx == REG_NUM_RINGS) v = v & 64'hF;
      if (idx == REG_SLICER_HI) v = v & 64'hFFFF_FFFF_FFFF;
      regs[idx] = v;
    endfunction

    function int rings_used();
      int n;
      n = regs[REG_NUM_RINGS][3:0];
      if (n < 1) n = 1;
      if (n > MAX_RINGS) n = MAX_RINGS;
      return n;
    endfunction

    function int count_of(int k);
      return regs[REG_RING_POINTS][8*k +: 8];
    endfunction

    function int unsigned lane(int lo, int k);
      logic [63:0] w;
      w = k[2] ? regs[lo+1] : regs[lo];
      return w[16*(k%4) +: 16];
    endfunction

    function int total_points();
      int t;
      t = 0;
      for (int k = 0; k < rings_used(); k++) t += count_of(k);
      return t;
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Rotation CORDIC: radius at angle, rounded to Q2.13
    function void rotate(int unsigned radius, int unsigned ang, ref apsk_point_t r);
      int unsigned a, t;
      int          sa;
      bit          neg;
      longint      x, y, z, dx, dy;
      longint unsigned prod;
      a = ang;
      neg = 0;
      t = a - 32'h4000_0000;
      if (t < 32'h8000_0000) begin
        a = a - 32'h8000_0000;
        neg = 1;
      end
      sa = a;
      z = sa;
      prod = (64'(radius) * 64'd652032874) >> 14;
      x = prod;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
        end
      end
      if (neg) begin
        x = -x; y = -y;
      end
      r.pi = clip16((x + 32768) >>> 16);
      r.pq = clip16((y + 32768) >>> 16);
    endfunction

    // Vectoring CORDIC: angle of a sample in turns
    function int unsigned angle_of(longint x, longint y);
      int unsigned z;
      longint      dx, dy;
      if (x == 0 && y == 0) return 0;
      z = 0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
        x = -x; y = -y; z = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ATAN_TURNS[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_TURNS[i];
        end
      end
      return z;
    endfunction

    function apsk_point_t map_symbol(int sym);
      apsk_point_t r;
      int          s, t, n, p, s0;
      bit          found;
      int unsigned ang;
      longint unsigned q;
      r = '{sym: sym[7:0], ring: 0, pi: 0, pq: 0, err: 1};
      if (sym >= MAP_DEPTH || sym >= total_points()) return r;
      s = sym_map[sym];
      t = 0;
      p = 0;
      found = 0;
      for (int k = 0; k < rings_used(); k++) begin
        n = count_of(k);
        if (!found && s < t + n) begin
          p = k; found = 1;
        end else if (!found) begin
          t += n;
        end
      end
      if (!found) return r;
      n = count_of(p);
      s0 = s - t;
      q = ((64'(s0) << 32) + 64'(n / 2)) / 64'(n);
      ang = (lane(REG_PHASE_LO, p) << 16) + q[31:0];
      r.ring = p;
      r.err = 0;
      rotate(lane(REG_RADIUS_LO, p), ang, r);
      return r;
    endfunction

    function apsk_point_t predict_result(logic [1:0] op, logic [7:0] idx, logic [7:0] val,
                                         logic [7:0] sym, logic signed [15:0] si,
                                         logic signed [15:0] sq);
      apsk_point_t r;
      longint      x, y, mag2, th;
      int          p, n, shat;
      int unsigned d;
      longint unsigned kk;
      r = '{sym: sym, ring: 0, pi: 0, pq: 0, err: 0};
      if (op == OP_LOAD) begin
        sym_map[idx] = val;
        inv_map[val] = idx;
      end else if (op == OP_MOD) begin
        r = map_symbol(sym);
      end else if (op == OP_DEMOD) begin
        x = si;
        y = sq;
        mag2 = x * x + y * y;
        p = rings_used() - 1;
        for (int k = rings_used() - 2; k >= 0; k--) begin
          th = lane(REG_SLICER_LO, k);
          if (mag2 < th * th) p = k;
        end
        n = count_of(p);
        kk = 0;
        if (n != 0) begin
          d = angle_of(x, y) - (lane(REG_PHASE_LO, p) << 16);
          kk = (64'(d) * 64'(n) + 64'h8000_0000) >> 32;
          if (kk >= n) kk = 0;
        end
        shat = kk;
        for (int k = 0; k < p; k++) shat += count_of(k);
        r = map_symbol((shat < MAP_DEPTH) ? int'(inv_map[shat]) : 0);
      end
      return r;
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] idx, logic [7:0] val,
                             logic [7:0] sym, logic signed [15:0] si,
                             logic signed [15:0] sq);
      pending_points.push_back(predict_result(op, idx, val, sym, si, sq));
    endfunction

    task report(string what);
      errors++;
      $display("mismatch @%0t: %s", $realtime, what);
    endtask

    task check_result(apsk_point_t got);
      apsk_point_t e;
      checked++;
      if (pending_points.size() == 0) begin
        report($sformatf("unexpected result sym=%0d", got.sym));
        return;
      end
      e = pending_points.pop_front();
      if (got.sym !== e.sym) report($sformatf("symbol %0d exp %0d", got.sym, e.sym));
      if (got.ring !== e.ring) report($sformatf("ring %0d exp %0d", got.ring, e.ring));
      if (got.pi !== e.pi) report($sformatf("point_i %0d exp %0d", got.pi, e.pi));
      if (got.pq !== e.pq) report($sformatf("point_q %0d exp %0d", got.pq, e.pq));
      if (got.err !== e.err) report($sformatf("range_error %0b exp %0b", got.err, e.err));
    endtask
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [1:0]           in_op = OP_LOAD;
  logic [7:0]           in_map_index = 0;
  logic [7:0]           in_map_value = 0;
  logic [7:0]           in_symbol = 0;
  logic signed [SW-1:0] in_sample_i = 0;
  logic signed [SW-1:0] in_sample_q = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic [7:0]           out_symbol_out;
  logic [2:0]           out_ring_index;
  logic signed [SW-1:0] out_point_i;
  logic signed [SW-1:0] out_point_q;
  logic                 out_range_error;
  logic                 cfg_we = 0;
  logic [CFG_IW-1:0]    cfg_index = REG_NUM_RINGS;
  logic [CFG_DW-1:0]    cfg_wdata = 0;

  apsk_symbol_book book = new();
  int idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int items_sent = 0;

  apsk_symbol_mapper_demapper dut (.*);

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("apsk_symbol_mapper_demapper_test: FAIL");
    $finish;
  end

  // Receiver stalls
  always @(negedge clk) begin
    if (idle_mode == 2) out_ready <= ($urandom_range(99) >= 55);
    else if (idle_mode == 3) out_ready <= ($urandom_range(99) >= 30);
    else out_ready <= 1'b1;
  end

  // Note accepted inputs, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        book.note_input(in_op, in_map_index, in_map_value, in_symbol, in_sample_i, in_sample_q);
      if (out_valid && out_ready)
        book.check_result('{sym: out_symbol_out, ring: out_ring_index, pi: out_point_i,
                            pq: out_point_q, err: out_range_error});
    end
  end

  // Drive one transfer; valid stays high across back-to-back items
  task send(logic [1:0] op, logic [7:0] idx, logic [7:0] val, logic [7:0] sym,
            logic signed [15:0] si, logic signed [15:0] sq);
    int gap;
    gap = 0;
    if ((idle_mode == 1 && $urandom_range(99) < 55) ||
        (idle_mode == 3 && $urandom_range(99) < 30))
      gap = $urandom_range(1, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_map_index <= idx;
    in_map_value <= val;
    in_symbol    <= sym;
    in_sample_i  <= si;
    in_sample_q  <= sq;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    items_sent++;
  endtask

  task drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write every register while the pipeline is empty
  task configure(logic [63:0] v [8]);
    drain();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IW-1:0];
      cfg_wdata <= v[i];
      book.set_reg(i, v[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task swap_entries(int a, int b);
    logic [7:0] va, vb;
    va = book.sym_map[a];
    vb = book.sym_map[b];
    send(OP_LOAD, a[7:0], vb, $urandom, $urandom, $urandom);
    send(OP_LOAD, b[7:0], va, $urandom, $urandom, $urandom);
  endtask

  task random_item();
    int          r, sym;
    apsk_point_t pt;
    r = $urandom_range(99);
    if (r < 12) begin
      swap_entries($urandom_range(255), $urandom_range(255));
    end else if (r < 40) begin
      sym = ($urandom_range(3) == 0) ? $urandom_range(255) :
            $urandom_range(book.total_points() > 0 ? book.total_points() - 1 : 0);
      send(OP_MOD, $urandom, $urandom, sym[7:0], $urandom, $urandom);
    end else if (r < 75) begin
      // noisy copy of a valid point
      pt = book.map_symbol($urandom_range(book.total_points() > 0 ?
                                          book.total_points() - 1 : 0));
      send(OP_DEMOD, $urandom, $urandom, $urandom,
           16'(book.clip16(longint'(pt.pi) + $urandom_range(600) - 300)),
           16'(book.clip16(longint'(pt.pq) + $urandom_range(600) - 300)));
    end else begin
      send(OP_DEMOD, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] v [8];
    int          perm [256];
    int          j, t;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the map with a random permutation so no entry is read unwritten
    foreach (perm[i]) perm[i] = i;
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    for (int i = 0; i < 256; i++)
      send(OP_LOAD, i[7:0], perm[i][7:0], $urandom, $urandom, $urandom);

    // Directed items at the reset setup
    swap_entries(0, 255);
    send(OP_MOD, 0, 0, 8'd0, 0, 0);
    send(OP_MOD, 0, 0, 8'd3, 0, 0);
    send(OP_MOD, 0, 0, 8'd4, 0, 0);
    send(OP_MOD, 8'hFF, 8'hFF, 8'd255, 16'sh7FFF, 16'sh7FFF);
    send(OP_DEMOD, 0, 0, 0, 16'sd0, 16'sd0);
    send(OP_DEMOD, 0, 0, 0, 16'sh7FFF, 16'sh7FFF);
    send(OP_DEMOD, 0, 0, 0, -16'sd32768, -16'sd32768);
    send(OP_DEMOD, 0, 0, 0, -16'sd32768, 16'sd0);
    send(OP_DEMOD, 0, 0, 0, 16'sd0, -16'sd32768);
    send(OP_DEMOD, 0, 0, 0, 16'sd8192, 16'sd0);
    send(OP_DEMOD, 0, 0, 0, 16'sd0, 16'sd8192);
    send(OP_DEMOD, 0, 0, 0, -16'sd8192, 16'sd0);
    send(OP_DEMOD, 0, 0, 0, 16'sd0, -16'sd8192);
    send(OP_IDLE, 8'hA5, 8'h5A, 8'hC3, 16'sh1234, -16'sd7);
    send(OP_IDLE, 8'h5A, 8'hA5, 8'h3C, -16'sd1, 16'sh4321);
    repeat (120) random_item();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: v = '{64'd4, 64'h0000_0000_1410_0C04, 64'h1C00_1600_1000_0A00, 64'd0,
                 {$urandom, $urandom}, 64'd0, 64'h0000_1900_1300_0D00, 64'd0};
        2: begin
          v[0] = 64'd8;
          for (int k = 0; k < 8; k++) v[1][8*k +: 8] = $urandom_range(1, 32);
          for (int k = 0; k < 4; k++) begin
            v[2][16*k +: 16] = 16'(2000 + 1500 * k);
            v[3][16*k +: 16] = 16'(8000 + 1500 * k);
            v[6][16*k +: 16] = 16'(2750 + 1500 * k);
          end
          v[4] = rand64(); v[5] = rand64();
          v[7] = {16'd0, 16'(14750), 16'(13250), 16'(11750)};
        end
        3: v = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        4: v = '{64'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0, 64'd0, 64'd0,
                 64'd0, 64'd0};
        default: begin
          foreach (v[k]) v[k] = rand64();
          for (int k = 0; k < 8; k++) v[1][8*k +: 8] = $urandom_range(0, 40);
        end
      endcase
      configure(v);
      idle_mode = ph % 4;
      for (int n = 0; n < 70; n++) begin
        if (ph == 5 && n == 35) drain();   // hold off until all results are back
        random_item();
      end
    end

    drain();
    repeat (70) @(posedge clk);
    $display("covered %0d transfers (%0d results) over 9 ring setups with mixed stalls",
             items_sent, book.checked);
    $display("ops: map loads, modulate incl. out-of-range symbols, demodulate incl. extremes");
    if (book.errors == 0 && book.pending_points.size() == 0) begin
      $display("apsk_symbol_mapper_demapper_test: PASS");
    end else begin
      $display("apsk_symbol_mapper_demapper_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== apsk_symbol_mapper_demapper.f =====
src/apsk_pkg.sv
src/apsk_ram.sv
src/apsk_vec.sv
src/apsk_div.sv
src/apsk_rot.sv
src/apsk_symbol_mapper_demapper.sv
verif/apsk_symbol_mapper_demapper_test.sv
